[rtl/kwl_pkg.sv]
`default_nettype none
package kwl_pkg;

  localparam int KW_COUNT    = 11;
  localparam int MAX_LEN_DEF = 64;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NAME,
    PH_COLON,
    PH_LESS,
    PH_GREATER,
    PH_HALT
  } phase_t;

  typedef enum logic [4:0] {
    TK_PROG     = 5'd0,
    TK_VAR      = 5'd1,
    TK_INT      = 5'd2,
    TK_REAL     = 5'd3,
    TK_BGN      = 5'd4,
    TK_END      = 5'd5,
    TK_IF       = 5'd6,
    TK_THEN     = 5'd7,
    TK_ELSE     = 5'd8,
    TK_WHL      = 5'd9,
    TK_DO       = 5'd10,
    TK_BECOMES  = 5'd11,
    TK_SEMI     = 5'd12,
    TK_TYPE_SEP = 5'd13,
    TK_LIST_SEP = 5'd14,
    TK_PERIOD   = 5'd15,
    TK_PLUS     = 5'd16,
    TK_SUB      = 5'd17,
    TK_STAR     = 5'd18,
    TK_SLASH    = 5'd19,
    TK_EQ       = 5'd20,
    TK_NEQ      = 5'd21,
    TK_LT       = 5'd22,
    TK_LEQ      = 5'd23,
    TK_GT       = 5'd24,
    TK_GEQ      = 5'd25,
    TK_IDENT    = 5'd26,
    TK_EOF      = 5'd27,
    TK_ERROR    = 5'd28
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } kwl_in_t;

  typedef struct packed {
    tok_kind_t   token_kind;
    logic [15:0] line_number;
    logic [6:0]  text_length;
    logic [7:0]  bad_char;
    logic        last_result;
  } kwl_out_t;

  // up to two tokens handed from the front to the queue per cycle
  typedef struct packed {
    logic [1:0] count;
    kwl_out_t   slot0;
    kwl_out_t   slot1;
  } kwl_push_t;

  // keyword spellings, left aligned and padded to seven characters
  localparam logic [0:KW_COUNT-1][55:0] KW_TEXT = {
    "program", "var    ", "integer", "real   ", "begin  ", "end    ",
    "if     ", "then   ", "else   ", "while  ", "do     "
  };
  localparam logic [0:KW_COUNT-1][2:0] KW_LEN = {
    3'd7, 3'd3, 3'd7, 3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2
  };

  // drop every keyword that does not have c at position len
  function automatic logic [KW_COUNT-1:0] kw_absorb(input logic [KW_COUNT-1:0] hits,
                                                     input logic [6:0] len,
                                                     input logic [7:0] c);
    logic [KW_COUNT-1:0] res;
    logic [7:0]          ch;
    res = hits;
    for (int k = 0; k < KW_COUNT; k++) begin
      ch = 8'h00;
      if (len < {4'd0, KW_LEN[k]}) begin
        ch = KW_TEXT[k][55 - 8 * int'(len[2:0]) -: 8];
      end
      if (len >= {4'd0, KW_LEN[k]} || ch != c) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic tok_kind_t kw_kind(input logic [KW_COUNT-1:0] hits,
                                        input logic [6:0] len);
    tok_kind_t res;
    res = TK_IDENT;
    // walk down so the lowest matching keyword wins
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (hits[k] && len == {4'd0, KW_LEN[k]}) begin
        res = tok_kind_t'(5'(k));
      end
    end
    return res;
  endfunction

  function automatic kwl_out_t mk_tok(input tok_kind_t kind, input logic [6:0] len,
                                      input logic [7:0] bad, input logic [15:0] line);
    kwl_out_t t;
    t.token_kind  = kind;
    t.line_number = line;
    t.text_length = len;
    t.bad_char    = bad;
    t.last_result = 1'b0;
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/keyword_token_lexer.sv]
`default_nettype none
// one source byte accepted per cycle while src_stall is low; the first token of
// a byte is written into the token queue and then into the output register
// a byte can make two tokens; the output register sends one per cycle unless
// tok_stall holds it, and a four-entry token queue absorbs the difference,
// stalling input when fewer than two entries are free
// reset (synchronous): scanner idle, line count 1, queue and output empty
module keyword_token_lexer #(
  parameter int MAX_LEN = kwl_pkg::MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   src_stall,
  input  wire kwl_pkg::kwl_in_t  src_beat,
  output logic                   tok_valid,
  input  wire logic              tok_stall,
  output kwl_pkg::kwl_out_t      tok_beat
);
  import kwl_pkg::*;

  kwl_push_t push;
  kwl_out_t  head;
  logic      head_valid, pop, full, accept;

  assign src_stall = full;
  assign accept    = src_valid && !src_stall;

  kwl_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (src_beat),
    .push   (push)
  );

  kwl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (full)
  );

  kwl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_beat   (tok_beat)
  );
endmodule
`default_nettype wire

[rtl/kwl_front.sv]
`default_nettype none
module kwl_front #(
  parameter int MAX_LEN = kwl_pkg::MAX_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire kwl_pkg::kwl_in_t   beat,
  output kwl_pkg::kwl_push_t      push
);
  import kwl_pkg::*;

  localparam logic [6:0] MAX_LEN_W = 7'(MAX_LEN);

  phase_t              phase, phase_next;
  logic [6:0]          name_len, name_len_next;
  logic [KW_COUNT-1:0] hits, hits_next;
  logic [15:0]         line_cnt, line_cnt_next;

  logic [7:0]          c;
  logic                eoi, live;
  logic                is_letter, is_digit, is_ws, is_nl, is_single;
  tok_kind_t           single_kind;
  logic [KW_COUNT-1:0] cont_hits, fresh_hits;
  logic [6:0]          cont_len;
  logic                cont_abs, cont_full, fresh_full, do_idle;

  logic                pend_v, new_v;
  kwl_out_t            pend_tok, new_tok;

  // byte classification
  always_comb begin
    c         = beat.source_byte;
    eoi       = beat.end_of_input;
    live      = accept && (phase != PH_HALT);
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_digit  = (c >= "0" && c <= "9");
    is_nl     = (c == 8'h0A);
    is_ws     = (c == " ") || (c == 8'h09) || is_nl || (c == 8'h0B) ||
                (c == 8'h0C) || (c == 8'h0D);
    is_single   = 1'b1;
    single_kind = TK_ERROR;
    case (c)
      ";":     single_kind = TK_SEMI;
      ",":     single_kind = TK_LIST_SEP;
      ".":     single_kind = TK_PERIOD;
      "+":     single_kind = TK_PLUS;
      "-":     single_kind = TK_SUB;
      "*":     single_kind = TK_STAR;
      "/":     single_kind = TK_SLASH;
      "=":     single_kind = TK_EQ;
      default: is_single = 1'b0;
    endcase
    cont_hits  = kw_absorb(hits, name_len, c);
    cont_len   = name_len + 7'd1;
    fresh_hits = kw_absorb({KW_COUNT{1'b1}}, 7'd0, c);
    cont_full  = cont_len >= MAX_LEN_W;
    fresh_full = 7'd1 >= MAX_LEN_W;
    cont_abs   = live && !eoi && (phase == PH_NAME) && (is_letter || is_digit);
    do_idle    = 1'b0;
    if (live && !eoi) begin
      case (phase)
        PH_IDLE:    do_idle = 1'b1;
        PH_NAME:    do_idle = !(is_letter || is_digit);
        PH_COLON:   do_idle = (c != "=");
        PH_LESS:    do_idle = (c != ">") && (c != "=");
        PH_GREATER: do_idle = (c != "=");
        default:    do_idle = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next    = phase;
    name_len_next = name_len;
    hits_next     = hits;
    line_cnt_next = line_cnt;
    if (live) begin
      if (eoi) begin
        phase_next    = PH_IDLE;
        name_len_next = 7'd0;
        hits_next     = {KW_COUNT{1'b1}};
        line_cnt_next = 16'd1;
      end else begin
        phase_next = PH_IDLE;
        if (cont_abs) begin
          name_len_next = cont_len;
          hits_next     = cont_hits;
          phase_next    = cont_full ? PH_IDLE : PH_NAME;
        end
        if (do_idle) begin
          if (is_ws) begin
            if (is_nl && line_cnt != 16'hFFFF) begin
              line_cnt_next = line_cnt + 16'd1;
            end
          end else if (is_letter) begin
            name_len_next = 7'd1;
            hits_next     = fresh_hits;
            phase_next    = fresh_full ? PH_IDLE : PH_NAME;
          end else if (c == ":") begin
            phase_next = PH_COLON;
          end else if (c == "<") begin
            phase_next = PH_LESS;
          end else if (c == ">") begin
            phase_next = PH_GREATER;
          end else if (!is_single) begin
            phase_next = PH_HALT;
          end
        end
      end
    end
  end

  // tokens: the pending one first, then the one this byte makes
  always_comb begin
    pend_v   = 1'b0;
    pend_tok = mk_tok(TK_IDENT, 7'd0, 8'd0, line_cnt);
    new_v    = 1'b0;
    new_tok  = mk_tok(TK_IDENT, 7'd0, 8'd0, line_cnt);
    if (live) begin
      case (phase)
        PH_NAME: begin
          if (eoi || !cont_abs) begin
            pend_v   = 1'b1;
            pend_tok = mk_tok(kw_kind(hits, name_len), name_len, 8'd0, line_cnt);
          end else if (cont_full) begin
            pend_v   = 1'b1;
            pend_tok = mk_tok(kw_kind(cont_hits, cont_len), cont_len, 8'd0, line_cnt);
          end
        end
        PH_COLON: begin
          pend_v = 1'b1;
          if (!eoi && c == "=") begin
            pend_tok = mk_tok(TK_BECOMES, 7'd2, 8'd0, line_cnt);
          end else begin
            pend_tok = mk_tok(TK_TYPE_SEP, 7'd1, 8'd0, line_cnt);
          end
        end
        PH_LESS: begin
          pend_v = 1'b1;
          if (!eoi && c == ">") begin
            pend_tok = mk_tok(TK_NEQ, 7'd2, 8'd0, line_cnt);
          end else if (!eoi && c == "=") begin
            pend_tok = mk_tok(TK_LEQ, 7'd2, 8'd0, line_cnt);
          end else begin
            pend_tok = mk_tok(TK_LT, 7'd1, 8'd0, line_cnt);
          end
        end
        PH_GREATER: begin
          pend_v = 1'b1;
          if (!eoi && c == "=") begin
            pend_tok = mk_tok(TK_GEQ, 7'd2, 8'd0, line_cnt);
          end else begin
            pend_tok = mk_tok(TK_GT, 7'd1, 8'd0, line_cnt);
          end
        end
        default: pend_v = 1'b0;
      endcase
      if (eoi) begin
        new_v   = 1'b1;
        new_tok = mk_tok(TK_EOF, 7'd0, 8'd0, line_cnt);
      end else if (do_idle) begin
        if (is_letter) begin
          new_v   = fresh_full;
          new_tok = mk_tok(kw_kind(fresh_hits, 7'd1), 7'd1, 8'd0, line_cnt);
        end else if (is_single) begin
          new_v   = 1'b1;
          new_tok = mk_tok(single_kind, 7'd1, 8'd0, line_cnt);
        end else if (!is_ws && c != ":" && c != "<" && c != ">") begin
          new_v   = 1'b1;
          new_tok = mk_tok(TK_ERROR, 7'd1, c, line_cnt);
        end
      end
    end
    push.count = {1'b0, pend_v} + {1'b0, new_v};
    push.slot0 = pend_v ? pend_tok : new_tok;
    push.slot1 = new_tok;
    push.slot0.last_result = !(pend_v && new_v);
    push.slot1.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      name_len <= 7'd0;
      hits     <= {KW_COUNT{1'b1}};
      line_cnt <= 16'd1;
    end else begin
      phase    <= phase_next;
      name_len <= name_len_next;
      hits     <= hits_next;
      line_cnt <= line_cnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |-> (push.count == 2'd0))
    else $error("tokens produced while halted");
  a_eoi_restart: assert property (@(posedge clk) disable iff (rst)
    (live && eoi) |=> (phase == PH_IDLE && line_cnt == 16'd1))
    else $error("end of input did not restart the scanner");
  a_eoi_token: assert property (@(posedge clk) disable iff (rst)
    (live && eoi) |-> (push.count != 2'd0))
    else $error("end of input produced no token");
`endif
endmodule
`default_nettype wire

[rtl/kwl_queue.sv]
`default_nettype none
module kwl_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kwl_pkg::kwl_push_t push,
  input  wire logic               pop,
  output logic                    head_valid,
  output kwl_pkg::kwl_out_t       head,
  output logic                    full
);
  import kwl_pkg::*;

  kwl_out_t          mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [Q_AW:0]     count, count_next;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  // the front may push two tokens, so hold it off unless two slots are free
  assign full       = (count > (Q_AW + 1)'(Q_DEPTH - 2));
  assign count_next = count + (Q_AW + 1)'(push.count) - (Q_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      mem[Q_AW'(wr_ptr + 1'b1)] <= push.slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.count);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> ((count + (Q_AW + 1)'(push.count)) <= (Q_AW + 1)'(Q_DEPTH)))
    else $error("token queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty token queue");
`endif
endmodule
`default_nettype wire

[rtl/kwl_back.sv]
`default_nettype none
module kwl_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire kwl_pkg::kwl_out_t head,
  output logic                   pop,
  output logic                   tok_valid,
  input  wire logic              tok_stall,
  output kwl_pkg::kwl_out_t      tok_beat
);
  import kwl_pkg::*;

  logic tok_valid_next;

  // refill the output register whenever it is empty or being taken
  assign pop            = head_valid && (!tok_valid || !tok_stall);
  assign tok_valid_next = pop || (tok_valid && tok_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tok_beat <= head;
    end
  end
endmodule
`default_nettype wire

[tb/sv/kwl_token_scoreboard.sv]
`default_nettype none
module kwl_token_scoreboard #(
  parameter int MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  input  wire logic              src_stall,
  input  wire kwl_pkg::kwl_in_t  src_beat,
  input  wire logic              tok_valid,
  input  wire logic              tok_stall,
  input  wire kwl_pkg::kwl_out_t tok_beat,
  output int                     fail_count,
  output int                     pending
);
  import kwl_pkg::*;

  localparam logic [0:10][55:0] SPELLING = {
    "program", "var    ", "integer", "real   ", "begin  ", "end    ",
    "if     ", "then   ", "else   ", "while  ", "do     "
  };

  phase_t      scan;
  logic [6:0]  name_len;
  logic [10:0] hits;
  logic [15:0] line;
  kwl_out_t    expected_tokens[$];
  int          mismatches;

  function automatic int word_len(input int k);
    case (k)
      0, 2:    return 7;
      1, 5:    return 3;
      3, 7, 8: return 4;
      4, 9:    return 5;
      default: return 2;
    endcase
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic reset_scan();
    scan     = PH_IDLE;
    name_len = '0;
    hits     = '1;
    line     = 16'd1;
  endtask

  task automatic emit(input tok_kind_t kind, input logic [6:0] len, input logic [7:0] bad);
    kwl_out_t t;
    t.token_kind  = kind;
    t.line_number = line;
    t.text_length = len;
    t.bad_char    = bad;
    t.last_result = 1'b0;
    expected_tokens.push_back(t);
  endtask

  // parallel keyword flags: drop each word that disagrees at this position
  task automatic take_char(input logic [7:0] c);
    int pos;
    pos = int'(name_len);
    for (int k = 0; k < 11; k++) begin
      if (pos >= word_len(k) || SPELLING[k][55 - 8 * pos -: 8] != c) begin
        hits[k] = 1'b0;
      end
    end
    name_len = name_len + 7'd1;
  endtask

  task automatic flush_pending();
    tok_kind_t kind;
    case (scan)
      PH_NAME: begin
        kind = TK_IDENT;
        for (int k = 10; k >= 0; k--) begin
          if (hits[k] && int'(name_len) == word_len(k)) begin
            kind = tok_kind_t'(5'(k));
          end
        end
        emit(kind, name_len, 8'h00);
      end
      PH_COLON:   emit(TK_TYPE_SEP, 7'd1, 8'h00);
      PH_LESS:    emit(TK_LT, 7'd1, 8'h00);
      PH_GREATER: emit(TK_GT, 7'd1, 8'h00);
      default: ;
    endcase
    scan = PH_IDLE;
  endtask

  task automatic start_token(input logic [7:0] c);
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      if (c == 8'h0A && line != 16'hFFFF) begin
        line = line + 16'd1;
      end
    end else if (is_letter(c)) begin
      scan     = PH_NAME;
      name_len = '0;
      hits     = '1;
      take_char(c);
      if (int'(name_len) >= MAX_LEN) begin
        flush_pending();
      end
    end else begin
      case (c)
        ":": scan = PH_COLON;
        "<": scan = PH_LESS;
        ">": scan = PH_GREATER;
        ";": emit(TK_SEMI, 7'd1, 8'h00);
        ",": emit(TK_LIST_SEP, 7'd1, 8'h00);
        ".": emit(TK_PERIOD, 7'd1, 8'h00);
        "+": emit(TK_PLUS, 7'd1, 8'h00);
        "-": emit(TK_SUB, 7'd1, 8'h00);
        "*": emit(TK_STAR, 7'd1, 8'h00);
        "/": emit(TK_SLASH, 7'd1, 8'h00);
        "=": emit(TK_EQ, 7'd1, 8'h00);
        default: begin
          scan = PH_HALT;
          emit(TK_ERROR, 7'd1, c);
        end
      endcase
    end
  endtask

  task automatic predict_tokens(input kwl_in_t b);
    int         had;
    logic [7:0] c;
    had = expected_tokens.size();
    c   = b.source_byte;
    if (scan == PH_HALT) begin
      // halted after an error: everything is swallowed until reset
    end else if (b.end_of_input) begin
      flush_pending();
      emit(TK_EOF, 7'd0, 8'h00);
      reset_scan();
    end else begin
      case (scan)
        PH_NAME: begin
          if (is_letter(c) || is_digit(c)) begin
            take_char(c);
            if (int'(name_len) >= MAX_LEN) begin
              flush_pending();
            end
          end else begin
            flush_pending();
            start_token(c);
          end
        end
        PH_COLON: begin
          scan = PH_IDLE;
          if (c == "=") begin
            emit(TK_BECOMES, 7'd2, 8'h00);
          end else begin
            emit(TK_TYPE_SEP, 7'd1, 8'h00);
            start_token(c);
          end
        end
        PH_LESS: begin
          scan = PH_IDLE;
          if (c == ">") begin
            emit(TK_NEQ, 7'd2, 8'h00);
          end else if (c == "=") begin
            emit(TK_LEQ, 7'd2, 8'h00);
          end else begin
            emit(TK_LT, 7'd1, 8'h00);
            start_token(c);
          end
        end
        PH_GREATER: begin
          scan = PH_IDLE;
          if (c == "=") begin
            emit(TK_GEQ, 7'd2, 8'h00);
          end else begin
            emit(TK_GT, 7'd1, 8'h00);
            start_token(c);
          end
        end
        default: begin
          scan = PH_IDLE;
          start_token(c);
        end
      endcase
    end
    if (expected_tokens.size() > had) begin
      expected_tokens[expected_tokens.size() - 1].last_result = 1'b1;
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: token %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_token(input kwl_out_t got);
    kwl_out_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: token expected none actual kind %0d line %0d length %0d", $time,
               int'(got.token_kind), got.line_number, got.text_length);
      mismatches++;
    end else begin
      want = expected_tokens.pop_front();
      check_field("kind", int'(want.token_kind), int'(got.token_kind));
      check_field("line", want.line_number, got.line_number);
      check_field("length", want.text_length, got.text_length);
      check_field("bad_char", want.bad_char, got.bad_char);
      check_field("last", want.last_result, got.last_result);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_scan();
      expected_tokens.delete();
      mismatches = 0;
    end else begin
      // a result can never come from a beat taken at the same edge
      if (tok_valid && !tok_stall) begin
        check_token(tok_beat);
      end
      if (src_valid && !src_stall) begin
        predict_tokens(src_beat);
      end
    end
    fail_count <= mismatches;
    pending    <= expected_tokens.size();
  end

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none
module tb;
  import kwl_pkg::*;

  localparam int MAX_LEN        = 64;
  localparam int RANDOM_ITEMS   = 300;
  localparam int NEWLINE_RUN    = 5;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  logic     clk;
  logic     rst       = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  kwl_in_t  src_beat  = '0;
  logic     tok_valid;
  logic     tok_stall = 1'b1;
  kwl_out_t tok_beat;

  int fail_count;
  int pending;
  int items_sent = 0;
  bit quiet = 1'b0;

  keyword_token_lexer #(.MAX_LEN(MAX_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_beat  (src_beat),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_beat  (tok_beat)
  );

  kwl_token_scoreboard #(.MAX_LEN(MAX_LEN)) scoreboard (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_beat   (src_beat),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_beat   (tok_beat),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? 8'h61 + r : 8'h41 + r;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eoi);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_beat  <= {b, eoi};
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b0);
    end
  endtask

  // a letter wherever a new name starts, so a split never begins with a digit
  task automatic send_name(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if (i % MAX_LEN == 0 || $urandom_range(0, 3) != 0) begin
        c = rand_letter();
      end else begin
        c = 8'h30 + 8'($urandom_range(0, 9));
      end
      send_beat(c, 1'b0);
    end
  endtask

  task automatic send_space();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'h20;
      1:       c = 8'h09;
      2:       c = 8'h0A;
      3:       c = 8'h0B;
      4:       c = 8'h0C;
      default: c = 8'h0D;
    endcase
    send_beat(c, 1'b0);
  endtask

  task automatic send_op();
    string ops;
    ops = ":<>;,.+-*/=";
    send_beat(ops[$urandom_range(0, 10)], 1'b0);
    if ($urandom_range(0, 2) == 0) begin
      send_beat($urandom_range(0, 1) ? "=" : ">", 1'b0);
    end
  endtask

  // names are always closed off so neighbors never merge into a long name
  task automatic close_name();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      send_beat(8'($urandom), 1'b1);
    end else if (r <= 3) begin
      send_op();
    end else begin
      send_space();
    end
  endtask

  task automatic send_word();
    int    pick;
    int    variant;
    string w;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      case ($urandom_range(0, 10))
        0:       w = "program";
        1:       w = "var";
        2:       w = "integer";
        3:       w = "real";
        4:       w = "begin";
        5:       w = "end";
        6:       w = "if";
        7:       w = "then";
        8:       w = "else";
        9:       w = "while";
        default: w = "do";
      endcase
      // exact keywords or near misses: capitalized, one char longer, one char short
      variant = $urandom_range(0, 5);
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if (i == 0 && variant == 0) begin
          c = c - 8'd32;
        end
        if (!(variant == 2 && i == w.len() - 1)) begin
          send_beat(c, 1'b0);
        end
      end
      if (variant == 1) begin
        send_beat($urandom_range(0, 1) ? rand_letter() : "7", 1'b0);
      end
      close_name();
    end else if (pick < 60) begin
      send_name($urandom_range(1, 8));
      close_name();
    end else if (pick < 88) begin
      send_op();
      if ($urandom_range(0, 1)) begin
        send_space();
      end
    end else if (pick < 95) begin
      send_beat(8'($urandom), 1'b1);
    end else begin
      case ($urandom_range(0, 3))
        0:       send_name(MAX_LEN - 1);
        1:       send_name(MAX_LEN);
        2:       send_name(MAX_LEN + 1);
        default: send_name(2 * MAX_LEN);
      endcase
      close_name();
    end
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stall before each beat, one long hold-off
  initial begin
    int taken;
    int gap;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        tok_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      tok_stall <= 1'b0;
      @(posedge clk);
      while (!(tok_valid && !tok_stall)) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int base;
    bit paused;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every operator, lookahead fallbacks, pending colon and name at end of input
    send_text(":=<><=>=:a<b>c;,.+-*/=\n\t:");
    send_beat(8'hFF, 1'b1);
    send_text("do");
    send_beat(8'h00, 1'b1);

    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      if (!paused && items_sent >= base + 200) begin
        wait_drained();
        paused = 1'b1;
      end
      quiet = items_sent >= base + 220 && items_sent < base + 290;
      send_word();
    end
    quiet = 1'b0;

    // a run of newlines, then end of input brings the line count back to one
    send_beat(8'h00, 1'b1);
    quiet = 1'b1;
    repeat (NEWLINE_RUN) send_beat(8'h0A, 1'b0);
    quiet = 1'b0;
    send_text("end x");
    send_beat(8'h80, 1'b1);
    send_text("if ");

    // digit right after a full-length name is an error; afterwards all is ignored
    send_name(MAX_LEN);
    send_beat("7", 1'b0);
    send_text("a@");
    send_beat(8'hFF, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
